/* rtl/gwm_pkg.sv */
// Package for the glob wildcard matcher: sizes, operation and status codes,
// controller state codes and the command and status structs.
// No dependencies.
package gwm_pkg;

    localparam int MAX_TEXT = 63;
    localparam int LEN_W    = $clog2(MAX_TEXT + 1);
    localparam int ROW_W    = MAX_TEXT + 1;

    localparam logic [1:0] OP_START   = 2'd0;
    localparam logic [1:0] OP_TEXT    = 2'd1;
    localparam logic [1:0] OP_PATTERN = 2'd2;
    localparam logic [1:0] OP_FINISH  = 2'd3;

    localparam logic [7:0] STAR_CODE  = 8'd42;
    localparam logic [7:0] QMARK_CODE = 8'd63;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_ORDER    = 2'd2;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_WALK = 1'b1;

    typedef struct packed {
        logic start;
        logic text;
        logic pat_load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic walk_last;
    } t_stat;

endpackage

/* rtl/gwm_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module gwm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/gwm_ctrl.sv */
// Controller for the glob wildcard matcher: decodes requests and sequences
// the walk over the match row. Depends on gwm_pkg.
module gwm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_op,
    input  gwm_pkg::t_stat i_stat,
    output gwm_pkg::t_cmd  o_cmd,
    output logic          o_busy
);

    logic r_state;
    logic n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            gwm_pkg::S_IDLE: begin
                if (i_start) begin
                    case (i_op)
                        gwm_pkg::OP_START: o_cmd.start = 1'b1;
                        gwm_pkg::OP_TEXT:  o_cmd.text = 1'b1;
                        gwm_pkg::OP_PATTERN: begin
                            o_cmd.pat_load = 1'b1;
                            if (!i_stat.len_zero) begin
                                n_state = gwm_pkg::S_WALK;
                            end
                        end
                        default: o_cmd.finish = 1'b1;
                    endcase
                end
            end
            gwm_pkg::S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.walk_last) begin
                    n_state = gwm_pkg::S_IDLE;
                end
            end
            default: n_state = gwm_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= gwm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state == gwm_pkg::S_WALK);

endmodule

/* rtl/gwm_datapath.sv */
// Datapath for the glob wildcard matcher: text store, match row, flags and
// the one-position-per-cycle row update. Depends on gwm_pkg and gwm_ram.
module gwm_datapath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  gwm_pkg::t_cmd  i_cmd,
    input  logic [7:0]    i_ch,
    output gwm_pkg::t_stat o_stat,
    output logic          o_valid,
    output logic          o_matched,
    output logic [1:0]    o_status
);

    localparam int LW = gwm_pkg::LEN_W;
    localparam int RW = gwm_pkg::ROW_W;

    logic [LW-1:0] r_len;
    logic [RW-1:0] r_row;
    logic [RW-1:0] r_new;
    logic [RW-1:0] n_new;
    logic          r_run;
    logic [LW-1:0] r_idx;
    logic [7:0]    r_pc;
    logic          r_pat_begun;
    logic          r_ovf;
    logic          r_ord;
    logic          r_valid;
    logic          r_matched;
    logic [1:0]    r_status;

    logic          ram_we;
    logic          ram_re;
    logic [LW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic          pc_star;
    logic          ld_star;
    logic          hit;
    logic          step_bit;
    logic          full;
    logic [1:0]    fin_status;

    assign full   = (r_len == LW'(gwm_pkg::MAX_TEXT));
    assign ram_we = i_cmd.text && !r_pat_begun && !full;
    assign ram_re = i_cmd.pat_load || (i_cmd.step && !o_stat.walk_last);
    assign ram_raddr = i_cmd.pat_load ? '0 : r_idx;

    gwm_ram #(
        .WIDTH(8),
        .DEPTH(gwm_pkg::MAX_TEXT)
    ) u_text_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_len),
        .i_wdata(i_ch),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign pc_star  = (r_pc == gwm_pkg::STAR_CODE);
    assign ld_star  = (i_ch == gwm_pkg::STAR_CODE);
    assign hit      = (r_pc == gwm_pkg::QMARK_CODE) || (r_pc == ram_rdata);
    assign step_bit = pc_star ? (r_run | r_row[r_idx])
                              : (hit & r_row[r_idx - LW'(1)]);

    always_comb begin
        n_new = r_new;
        n_new[r_idx] = step_bit;
    end

    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.walk_last = (r_idx == r_len);

    always_comb begin
        if (r_ovf) begin
            fin_status = gwm_pkg::ST_OVERFLOW;
        end else if (r_ord) begin
            fin_status = gwm_pkg::ST_ORDER;
        end else begin
            fin_status = gwm_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_row       <= RW'(1);
            r_pat_begun <= 1'b0;
            r_ovf       <= 1'b0;
            r_ord       <= 1'b0;
            r_valid     <= 1'b0;
        end else begin
            r_valid <= i_cmd.finish;
            if (i_cmd.start) begin
                r_len       <= '0;
                r_row       <= RW'(1);
                r_pat_begun <= 1'b0;
                r_ovf       <= 1'b0;
                r_ord       <= 1'b0;
            end
            if (i_cmd.text) begin
                if (r_pat_begun) begin
                    r_ord <= 1'b1;
                end else if (full) begin
                    r_ovf <= 1'b1;
                end else begin
                    r_len <= r_len + LW'(1);
                end
            end
            if (i_cmd.pat_load) begin
                r_pat_begun <= 1'b1;
                if (r_len == '0) begin
                    r_row <= RW'(ld_star & r_row[0]);
                end
            end
            if (i_cmd.step && o_stat.walk_last) begin
                r_row <= n_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.pat_load) begin
            r_pc  <= i_ch;
            r_run <= r_row[0];
            r_new <= RW'(ld_star & r_row[0]);
            r_idx <= LW'(1);
        end
        if (i_cmd.step) begin
            r_run <= r_run | r_row[r_idx];
            r_new <= n_new;
            r_idx <= r_idx + LW'(1);
        end
        if (i_cmd.finish) begin
            r_status  <= fin_status;
            r_matched <= (fin_status == gwm_pkg::ST_OK) && r_row[r_len];
        end
    end

    assign o_valid   = r_valid;
    assign o_matched = r_matched;
    assign o_status  = r_status;

endmodule

/* rtl/glob_wildcard_matcher_top.sv */
// Top level of the glob wildcard matcher: controller plus datapath.
// Depends on gwm_pkg, gwm_ctrl, gwm_datapath and gwm_ram.
//
// Channel   Direction  Ports                      Handshake
// request   in         i_op, i_ch                 i_start high while o_busy low
// result    out        o_matched, o_status        o_valid strobe, one cycle
//
// Start, text and finish requests leave o_busy low; a finish result appears
// on the cycle after its request. A pattern request on a nonempty text starts
// a row walk, which visits one text position a cycle, paced by the read
// port of the text RAM. The reset is synchronous and active low and
// needs no clearing pass. The receiver cannot stall results.
module glob_wildcard_matcher_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    output logic       o_busy,
    output logic       o_valid,
    output logic       o_matched,
    output logic [1:0] o_status
);

    gwm_pkg::t_cmd  cmd;
    gwm_pkg::t_stat stat;

    gwm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_op   (i_op),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (o_busy)
    );

    gwm_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_ch     (i_ch),
        .o_stat   (stat),
        .o_valid  (o_valid),
        .o_matched(o_matched),
        .o_status (o_status)
    );

    a_no_valid_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_valid && o_busy))
        else $error("result strobe during a row walk");

    a_valid_after_finish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start && !o_busy && (i_op == gwm_pkg::OP_FINISH)))
        else $error("result strobe without a finish request");

    a_flag_forces_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_status != gwm_pkg::ST_OK)) |-> !o_matched)
        else $error("match reported with an error status");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status != 2'd3))
        else $error("undefined status code");

endmodule
